// ----- hw/rtl/mtep_pkg.sv -----
// shared types and constants for the midi track event parser
// no dependencies
package mtep_pkg;

    localparam int DELTA_BYTES_MAX_DEF = 4;
    localparam int QDEPTH = 2;

    localparam logic [2:0] EV_DELTA = 3'd0;
    localparam logic [2:0] EV_NOTE_ON = 3'd1;
    localparam logic [2:0] EV_NOTE_OFF = 3'd2;
    localparam logic [2:0] EV_TEMPO = 3'd3;
    localparam logic [2:0] EV_KEY = 3'd4;
    localparam logic [2:0] EV_TIME = 3'd5;
    localparam logic [2:0] EV_END = 3'd6;
    localparam logic [2:0] EV_TEMPO_ERR = 3'd7;

    localparam logic [7:0] META_END = 8'h2F;
    localparam logic [7:0] META_TEMPO = 8'h51;
    localparam logic [7:0] META_KEY = 8'h59;
    localparam logic [7:0] META_TIME = 8'h58;
    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END = 8'hF7;
    localparam logic [7:0] META_START = 8'hFF;
    localparam logic [25:0] TEMPO_NUM = 26'd60000000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  chan;
        logic [6:0]  note;
        logic [6:0]  vel;
        logic [27:0] value;
        logic [15:0] second;
        logic        minor;
        logic        divide;
    } t_event;

endpackage

// ----- hw/rtl/mtep_front.sv -----
// byte classifier: parse phase, running status and field decode
// depends on mtep_pkg
module mtep_front #(
    parameter int DELTA_BYTES_MAX = mtep_pkg::DELTA_BYTES_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_byte,
    output logic             o_ev_valid,
    input  logic             i_ev_ready,
    output mtep_pkg::t_event o_ev
);
    localparam logic [3:0] PH_DELTA = 4'd0;
    localparam logic [3:0] PH_STATUS = 4'd1;
    localparam logic [3:0] PH_KEY = 4'd2;
    localparam logic [3:0] PH_VEL = 4'd3;
    localparam logic [3:0] PH_SKIP = 4'd4;
    localparam logic [3:0] PH_SYSEX = 4'd5;
    localparam logic [3:0] PH_MTYPE = 4'd6;
    localparam logic [3:0] PH_MLEN = 4'd7;
    localparam logic [3:0] PH_MDATA = 4'd8;

    logic [3:0]  r_phase, n_phase;
    logic [7:0]  r_rs, n_rs, r_first, n_first, r_mtype, n_mtype, r_skip, n_skip;
    logic [27:0] r_acc, n_acc;
    logic        r_ended, n_ended;
    logic        emit;
    mtep_pkg::t_event ev;
    logic [7:0]  s, cnt, dec;
    logic        take;

    assign o_ready = i_ev_ready;
    assign take = i_valid && o_ready;
    assign o_ev_valid = take && emit;
    assign o_ev = ev;
    assign cnt = r_skip + 8'd1;
    assign dec = r_skip - 8'd1;

    always_comb begin
        n_phase = r_phase; n_rs = r_rs; n_first = r_first; n_mtype = r_mtype;
        n_skip = r_skip; n_acc = r_acc; n_ended = r_ended;
        emit = 1'b0; ev = '0; s = r_rs;
        if (!r_ended) begin
            unique case (r_phase)
                PH_DELTA: begin
                    n_acc = {r_acc[20:0], i_byte[6:0]};
                    n_skip = cnt;
                    if (!(i_byte[7] && 32'(cnt) < DELTA_BYTES_MAX)) begin
                        emit = 1'b1; ev.kind = mtep_pkg::EV_DELTA; ev.value = n_acc;
                        n_acc = '0; n_skip = '0; n_phase = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    if (!i_byte[7] && r_rs[7] && r_rs < 8'hF0) s = r_rs;
                    else s = i_byte;
                    if (!i_byte[7] && !(r_rs[7] && r_rs < 8'hF0)) begin
                        n_phase = PH_DELTA;
                    end else if (s < 8'hF0) begin
                        n_rs = s;
                        if (s < 8'hA0) begin
                            n_phase = PH_KEY;
                            if (!i_byte[7]) begin
                                n_first = {1'b0, i_byte[6:0]}; n_phase = PH_VEL;
                            end
                        end else begin
                            n_skip = (s[7:5] == 3'b110) ? 8'd1 : 8'd2;
                            n_phase = PH_SKIP;
                            if (!i_byte[7]) begin
                                n_skip = n_skip - 8'd1;
                                if (n_skip == 8'd0) n_phase = PH_DELTA;
                            end
                        end
                    end else begin
                        n_rs = '0; n_phase = PH_DELTA;
                        if (i_byte == mtep_pkg::SYSEX_START) n_phase = PH_SYSEX;
                        else if (i_byte == mtep_pkg::META_START) n_phase = PH_MTYPE;
                        else if (i_byte == 8'hF1 || i_byte == 8'hF3) begin
                            n_skip = 8'd1; n_phase = PH_SKIP;
                        end else if (i_byte == 8'hF2) begin
                            n_skip = 8'd2; n_phase = PH_SKIP;
                        end
                    end
                end
                PH_KEY: begin
                    n_first = {1'b0, i_byte[6:0]}; n_phase = PH_VEL;
                end
                PH_SKIP: begin
                    n_skip = dec;
                    if (dec == 8'd0) n_phase = PH_DELTA;
                end
                PH_VEL: begin
                    n_phase = PH_DELTA; emit = 1'b1;
                    ev.chan = r_rs[3:0]; ev.note = r_first[6:0];
                    if (r_rs < 8'h90 || i_byte[6:0] == 7'd0) begin
                        ev.kind = mtep_pkg::EV_NOTE_OFF;
                    end else begin
                        ev.kind = mtep_pkg::EV_NOTE_ON; ev.vel = i_byte[6:0];
                    end
                end
                PH_SYSEX: if (i_byte == mtep_pkg::SYSEX_END) n_phase = PH_DELTA;
                PH_MTYPE: begin
                    n_mtype = i_byte; n_phase = PH_MLEN;
                    if (i_byte == mtep_pkg::META_END) begin
                        n_ended = 1'b1; emit = 1'b1; ev.kind = mtep_pkg::EV_END;
                    end
                end
                PH_MLEN: begin
                    n_acc = '0; n_phase = PH_MDATA;
                    if (r_mtype == mtep_pkg::META_TEMPO) n_skip = 8'd3;
                    else if (r_mtype == mtep_pkg::META_KEY) n_skip = 8'd2;
                    else if (r_mtype == mtep_pkg::META_TIME) n_skip = 8'd4;
                    else begin
                        n_skip = i_byte;
                        n_phase = (i_byte == 8'd0) ? PH_DELTA : PH_SKIP;
                    end
                end
                PH_MDATA: begin
                    n_skip = dec;
                    if (r_mtype == mtep_pkg::META_TEMPO) begin
                        n_acc = {r_acc[19:0], i_byte};
                        if (dec == 8'd0) begin
                            n_phase = PH_DELTA; emit = 1'b1; ev.value = n_acc;
                            n_acc = '0;
                            if (ev.value == 28'd0) ev.kind = mtep_pkg::EV_TEMPO_ERR;
                            else begin
                                ev.kind = mtep_pkg::EV_TEMPO; ev.divide = 1'b1;
                            end
                        end
                    end else if (r_mtype == mtep_pkg::META_KEY) begin
                        if (dec != 8'd0) n_first = i_byte;
                        else begin
                            n_phase = PH_DELTA; emit = 1'b1; ev.kind = mtep_pkg::EV_KEY;
                            ev.value = {20'd0, r_first + 8'd7};
                            ev.minor = (i_byte != 8'd0);
                        end
                    end else begin
                        if (dec == 8'd3) n_first = i_byte;
                        else if (dec == 8'd2) n_acc = {20'd0, i_byte};
                        if (dec == 8'd0) begin
                            n_phase = PH_DELTA; emit = 1'b1; ev.kind = mtep_pkg::EV_TIME;
                            ev.value = {20'd0, n_first};
                            if (n_acc[7:4] == 4'd0) ev.second = 16'd1 << n_acc[3:0];
                            else ev.second = {8'd0, n_acc[7:0]};
                            n_acc = '0;
                        end
                    end
                end
                default: n_phase = PH_DELTA;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DELTA; r_rs <= '0; r_first <= '0; r_mtype <= '0;
            r_skip <= '0; r_acc <= '0; r_ended <= 1'b0;
        end else if (take) begin
            r_phase <= n_phase; r_rs <= n_rs; r_first <= n_first; r_mtype <= n_mtype;
            r_skip <= n_skip; r_acc <= n_acc; r_ended <= n_ended;
        end
    end

    a_end_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ended |=> r_ended) else $error("end flag dropped");
    a_no_emit_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ended |-> !o_ev_valid) else $error("event after end of track");
    a_vel_from_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_VEL) |-> (r_rs >= 8'h80 && r_rs < 8'hA0))
        else $error("velocity phase without note status");
endmodule

// ----- hw/rtl/mtep_queue.sv -----
// small event fifo between classifier and executor
// depends on mtep_pkg
module mtep_queue #(
    parameter int DEPTH = mtep_pkg::QDEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  mtep_pkg::t_event i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output mtep_pkg::t_event o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    mtep_pkg::t_event r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          wr, rd;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (32'(r_wp) == DEPTH - 1) ? '0 : r_wp + 1'b1;
            if (rd) r_rp <= (32'(r_rp) == DEPTH - 1) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (AW+1)'(DEPTH)) |-> !wr) else $error("queue overflow");
endmodule

// ----- hw/rtl/mtep_back.sv -----
// executor: restoring divider for tempo, output register
// depends on mtep_pkg
module mtep_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  mtep_pkg::t_event i_ev,
    output logic             o_valid,
    input  logic             i_ready,
    output mtep_pkg::t_event o_ev
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV = 2'd1;
    localparam logic [1:0] ST_OUT = 2'd2;
    localparam logic [1:0] ST_FIN = 2'd3;

    logic [1:0]  r_st;
    logic [4:0]  r_bit;
    logic [25:0] r_quo;
    logic [27:0] r_rem, r_div;
    mtep_pkg::t_event r_ev;
    logic [28:0] trial;

    assign o_ready = (r_st == ST_IDLE) || (r_st == ST_OUT && i_ready);
    assign o_valid = (r_st == ST_OUT);
    assign o_ev = r_ev;
    assign trial = {r_rem, mtep_pkg::TEMPO_NUM[r_bit]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else begin
            unique case (r_st)
                ST_IDLE, ST_OUT: begin
                    if (o_ready) begin
                        if (i_valid) begin
                            r_ev <= i_ev;
                            r_st <= i_ev.divide ? ST_DIV : ST_OUT;
                            r_div <= i_ev.value; r_rem <= '0; r_bit <= 5'd25;
                        end else r_st <= ST_IDLE;
                    end
                end
                ST_DIV: begin
                    if (trial >= {1'b0, r_div}) begin
                        r_rem <= 28'(trial - {1'b0, r_div}); r_quo[r_bit] <= 1'b1;
                    end else begin
                        r_rem <= trial[27:0]; r_quo[r_bit] <= 1'b0;
                    end
                    if (r_bit == 5'd0) r_st <= ST_FIN;
                    else r_bit <= r_bit - 5'd1;
                end
                ST_FIN: begin
                    r_ev.value <= {2'd0, r_quo}; r_ev.divide <= 1'b0; r_st <= ST_OUT;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DIV) |-> (r_div != '0)) else $error("divide by zero");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped");
endmodule

// ----- hw/rtl/midi_track_event_parser.sv -----
// midi track event parser top: classifier, event queue, executor
// depends on mtep_pkg, mtep_front, mtep_queue, mtep_back
// one byte per cycle unless the queue fills; results pass queue then output register
// a tempo event also passes through the bit-serial divider before output; bytes keep flowing
// until the two-entry queue fills, then input stalls
// synchronous active-low reset returns to expecting a delta time, clears running status
module midi_track_event_parser #(
    parameter int DELTA_BYTES_MAX = mtep_pkg::DELTA_BYTES_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_track_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_event_kind,
    output logic [3:0]  o_midi_channel,
    output logic [6:0]  o_note_number,
    output logic [6:0]  o_note_velocity,
    output logic [27:0] o_event_value,
    output logic [15:0] o_second_value,
    output logic        o_minor_mode
);
    logic f_valid, f_ready, q_valid, q_ready;
    mtep_pkg::t_event f_ev, q_ev, b_ev;

    mtep_front #(.DELTA_BYTES_MAX(DELTA_BYTES_MAX)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_byte(i_track_byte),
        .o_ev_valid(f_valid), .i_ev_ready(f_ready), .o_ev(f_ev));

    mtep_queue #(.DEPTH(mtep_pkg::QDEPTH)) u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_ready(f_ready), .i_data(f_ev),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_ev));

    mtep_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_ready(q_ready), .i_ev(q_ev),
        .o_valid, .i_ready, .o_ev(b_ev));

    assign o_event_kind = b_ev.kind;
    assign o_midi_channel = b_ev.chan;
    assign o_note_number = b_ev.note;
    assign o_note_velocity = b_ev.vel;
    assign o_event_value = b_ev.value;
    assign o_second_value = b_ev.second;
    assign o_minor_mode = b_ev.minor;
endmodule
